FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the double-ended queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define DEQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/deq_pkg.sv
// Types and constants of the double-ended queue.
package deq_pkg;

  localparam int OP_W       = 3;
  localparam int STATUS_W   = 2;
  localparam int CAP_RESET  = 10;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_ctrl_t;

endpackage

FILE: sv/deq_if.sv
// Request and response channel interfaces of the double-ended queue.
interface deq_req_if #(
  parameter int WORD_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::OP_W-1:0]      op;
  logic signed [WORD_BITS-1:0]   key;

  modport source (output valid, op, key, input ready);
  modport sink (input valid, op, key, output ready);
endinterface

interface deq_rsp_if #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 5
);
  logic                           valid;
  logic                           ready;
  logic [deq_pkg::STATUS_W-1:0]   status;
  logic signed [WORD_BITS-1:0]    front_word;
  logic signed [WORD_BITS-1:0]    rear_word;
  logic                           is_empty;
  logic                           is_full;
  logic [CNT_W-1:0]               occupancy;

  modport source (output valid, status, front_word, rear_word, is_empty, is_full, occupancy,
                  input ready);
  modport sink (input valid, status, front_word, rear_word, is_empty, is_full, occupancy,
                output ready);
endinterface

FILE: sv/double_ended_queue_top.sv
// Top level of the double-ended queue: cell row, occupancy control and register port.
// The deque keeps its words in a row of DEPTH cells with the front word always in the first
// cell; an insert or delete at the front shifts the whole row by one place, while an operation
// at the rear touches only the cell at the boundary of the occupied run. Each request beat is
// answered by exactly one response beat in the cycle after it is accepted, and a new request is
// taken in every cycle while the response register is empty or being drained, so the block
// sustains one operation per clock; that rate is set by the cell row being updated together with
// the response register. The capacity register at byte address 0 is reset to 10, reads back
// its stored value, and is clipped to the range 1 to DEPTH when used.
module double_ended_queue_top #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  deq_req_if.sink                           req_i,
  deq_rsp_if.source                         rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [deq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [deq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [deq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]     cap_q, cap_eff;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 full, empty, accept, cfg_wr;
  deq_pkg::cell_ctrl_t  ctrl;
  deq_pkg::status_e     status_d;

  logic [DEPTH-1:0]                 occ_q, occ_d, last_d;
  logic [DEPTH-1:0][WORD_BITS-1:0]  data_q, data_d;
  logic [WORD_BITS-1:0]             front_d, rear_d;

  logic                             rsp_valid_q;
  deq_pkg::status_e                 status_q;
  logic [WORD_BITS-1:0]             front_q, rear_q;
  logic                             empty_q, full_q;
  logic [CNT_W-1:0]                 occupancy_q;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[deq_pkg::APB_ADDR_W-1];
  assign prdata = paddr[deq_pkg::APB_ADDR_W-1] ? '0 : deq_pkg::APB_DATA_W'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_W'(deq_pkg::CAP_RESET);
    end else if (cfg_wr) begin
      cap_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Request decode.
  assign full         = count_q >= cap_eff;
  assign empty        = count_q == '0;
  assign req_i.ready  = !rsp_valid_q || rsp_o.ready;
  assign accept       = req_i.valid && req_i.ready;

  always_comb begin
    ctrl     = '0;
    status_d = deq_pkg::ST_OK;
    count_d  = count_q;
    unique case (deq_pkg::op_e'(req_i.op))
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          status_d = deq_pkg::ST_OVERFLOW;
        end else begin
          ctrl.push_front = accept && (deq_pkg::op_e'(req_i.op) == deq_pkg::OP_PUSH_FRONT);
          ctrl.push_rear  = accept && (deq_pkg::op_e'(req_i.op) == deq_pkg::OP_PUSH_REAR);
          count_d         = count_q + CNT_W'(1);
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_REAR: begin
        if (empty) begin
          status_d = deq_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.pop_front = accept && (deq_pkg::op_e'(req_i.op) == deq_pkg::OP_POP_FRONT);
          ctrl.pop_rear  = accept && (deq_pkg::op_e'(req_i.op) == deq_pkg::OP_POP_REAR);
          count_d        = count_q - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Cell row.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_data, right_data;
    logic                 left_occ, right_occ;

    if (i == 0) begin : g_first
      assign left_data = req_i.key;
      assign left_occ  = 1'b1;
    end else begin : g_inner_left
      assign left_data = data_q[i-1];
      assign left_occ  = occ_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
      assign right_occ  = 1'b0;
      assign last_d[i]  = occ_d[i];
    end else begin : g_inner_right
      assign right_data = data_q[i+1];
      assign right_occ  = occ_q[i+1];
      assign last_d[i]  = occ_d[i] && !occ_d[i+1];
    end

    deq_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (req_i.key),
      .left_data_i  (left_data),
      .left_occ_i   (left_occ),
      .right_data_i (right_data),
      .right_occ_i  (right_occ),
      .data_o       (data_q[i]),
      .occ_o        (occ_q[i]),
      .data_nxt_o   (data_d[i]),
      .occ_nxt_o    (occ_d[i])
    );
  end

  assign front_d = occ_d[0] ? data_d[0] : '0;

  always_comb begin
    rear_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_d = rear_d | (last_d[i] ? data_d[i] : '0);
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      empty_q     <= count_d == '0;
      full_q      <= count_d >= cap_eff;
      occupancy_q <= count_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.front_word = front_q;
  assign rsp_o.rear_word  = rear_q;
  assign rsp_o.is_empty   = empty_q;
  assign rsp_o.is_full    = full_q;
  assign rsp_o.occupancy  = occupancy_q;

  `DEQ_ASSERT_NEVER(a_count_in_range, count_q > CNT_W'(DEPTH), "entry count exceeds depth")
  `DEQ_ASSERT(a_occ_matches_count, $countones(occ_q) == 32'(count_q), "cell row disagrees with count")
  `DEQ_ASSERT(a_overflow_keeps_count, accept && status_d == deq_pkg::ST_OVERFLOW |=> count_q == $past(count_q), "overflow changed the count")
  `DEQ_ASSERT(a_empty_words_zero, rsp_valid_q && empty_q |-> front_q == '0 && rear_q == '0, "empty deque reports a word")

endmodule

FILE: sv/deq_cell.sv
// One storage cell of the deque row, shifting towards either neighbour.
module deq_cell #(
  parameter int WORD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  deq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [WORD_BITS-1:0]    key_i,
  input  logic [WORD_BITS-1:0]    left_data_i,
  input  logic                    left_occ_i,
  input  logic [WORD_BITS-1:0]    right_data_i,
  input  logic                    right_occ_i,
  output logic [WORD_BITS-1:0]    data_o,
  output logic                    occ_o,
  output logic [WORD_BITS-1:0]    data_nxt_o,
  output logic                    occ_nxt_o
);

  logic [WORD_BITS-1:0] data_q, data_d;
  logic                 occ_q, occ_d;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (ctrl_i.push_front) begin
      data_d = left_data_i;
      occ_d  = left_occ_i;
    end else if (ctrl_i.push_rear) begin
      if (!occ_q && left_occ_i) begin
        data_d = key_i;
        occ_d  = 1'b1;
      end
    end else if (ctrl_i.pop_front) begin
      data_d = right_data_i;
      occ_d  = right_occ_i;
    end else if (ctrl_i.pop_rear) begin
      if (occ_q && !right_occ_i) begin
        occ_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign occ_o      = occ_q;
  assign data_nxt_o = data_d;
  assign occ_nxt_o  = occ_d;

endmodule

FILE: sim/double_ended_queue_top_tb.sv
// Self-checking testbench for the double-ended queue against a shadow deque.
`timescale 1ns / 100ps

typedef struct packed {
  logic [1:0]  status;
  logic [31:0] front_word;
  logic [31:0] rear_word;
  logic        is_empty;
  logic        is_full;
  logic [4:0]  occupancy;
} deque_reply_t;

class deque_shadow;
  localparam int SLOTS = 16;

  logic [31:0]  slot_word [SLOTS];
  logic [3:0]   head_slot;
  logic [4:0]   held;
  logic [4:0]   capacity;
  deque_reply_t expected_replies[$];
  int           mismatches;

  function new();
    head_slot  = '0;
    held       = '0;
    capacity   = 5'(deq_pkg::CAP_RESET);
    mismatches = 0;
    foreach (slot_word[i]) slot_word[i] = '0;
  endfunction

  function void set_capacity(logic [4:0] value);
    capacity = value;
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction

  function logic [3:0] rear_slot();
    return head_slot + 4'(held) - 4'd1;
  endfunction

  // Applies one operation to the shadow deque and queues the reply it must produce.
  function void apply_op(logic [2:0] op, logic [31:0] key);
    logic [4:0]   cap_used;
    logic         full_now;
    deque_reply_t reply;
    cap_used = (capacity == 0) ? 5'd1 : (capacity > SLOTS) ? 5'(SLOTS) : capacity;
    full_now = held >= cap_used;
    reply.status = deq_pkg::ST_OK;
    case (op)
      deq_pkg::OP_PUSH_FRONT: begin
        if (full_now) begin
          reply.status = deq_pkg::ST_OVERFLOW;
        end else begin
          head_slot = head_slot - 4'd1;
          slot_word[head_slot] = key;
          held = held + 5'd1;
        end
      end
      deq_pkg::OP_PUSH_REAR: begin
        if (full_now) begin
          reply.status = deq_pkg::ST_OVERFLOW;
        end else begin
          held = held + 5'd1;
          slot_word[rear_slot()] = key;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (held == 0) begin
          reply.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          head_slot = head_slot + 4'd1;
          held = held - 5'd1;
        end
      end
      deq_pkg::OP_POP_REAR: begin
        if (held == 0) begin
          reply.status = deq_pkg::ST_UNDERFLOW;
        end else begin
          held = held - 5'd1;
        end
      end
      default: begin
      end
    endcase
    reply.front_word = (held == 0) ? '0 : slot_word[head_slot];
    reply.rear_word  = (held == 0) ? '0 : slot_word[rear_slot()];
    reply.is_empty   = (held == 0);
    reply.is_full    = (held >= cap_used);
    reply.occupancy  = held;
    expected_replies.push_back(reply);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
      end
    end
  endfunction

  function void check_reply(deque_reply_t got);
    deque_reply_t want;
    if (expected_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected reply beat %p", $realtime, got);
      end
      return;
    end
    want = expected_replies.pop_front();
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("front_word", want.front_word, got.front_word);
    compare_field("rear_word", want.rear_word, got.rear_word);
    compare_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
    compare_field("is_full", 32'(want.is_full), 32'(got.is_full));
    compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
  endfunction

  function void close_out();
    if (expected_replies.size() != 0) begin
      mismatches += expected_replies.size();
      $display("%0d expected replies never arrived", expected_replies.size());
    end
  endfunction
endclass

module double_ended_queue_top_tb;

  localparam int REG_CAPACITY = 0;
  localparam logic [deq_pkg::APB_ADDR_W-1:0] CAPACITY_ADDR =
    deq_pkg::APB_ADDR_W'(4 * REG_CAPACITY);
  localparam int BATCHES    = 9;
  localparam int BATCH_OPS  = 214;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [deq_pkg::APB_ADDR_W-1:0] paddr;
  logic [deq_pkg::APB_DATA_W-1:0] pwdata, prdata;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int insert_bias       = 50;

  deque_shadow shadow = new();

  deq_req_if #(.WORD_BITS(32)) req_if ();
  deq_rsp_if #(.WORD_BITS(32), .CNT_W(5)) rsp_if ();

  double_ended_queue_top #(
    .DEPTH     (16),
    .WORD_BITS (32)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    req_if.valid  = 1'b0;
    req_if.op     = '0;
    req_if.key    = '0;
    rsp_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        shadow.apply_op(req_if.op, req_if.key);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        shadow.check_reply({rsp_if.status, rsp_if.front_word, rsp_if.rear_word,
                            rsp_if.is_empty, rsp_if.is_full, rsp_if.occupancy});
      end
    end
  end

  task automatic send_op(logic [2:0] op, logic [31:0] key);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op    <= op;
    req_if.key   <= key;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_replies_done();
    req_if.valid <= 1'b0;
    while (shadow.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= deq_pkg::APB_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow.set_capacity(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return deq_pkg::OP_QUERY;
    if (roll < 6) return 3'($urandom_range(5, 7));
    if ($urandom_range(0, 99) < insert_bias) begin
      return ($urandom_range(0, 1) != 0) ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT;
    end
    return ($urandom_range(0, 1) != 0) ? deq_pkg::OP_POP_REAR : deq_pkg::OP_POP_FRONT;
  endfunction

  initial begin
    logic [4:0] capacities [BATCHES];
    int         bias_choice [3];

    capacities  = '{5'd16, 5'd1, 5'd0, 5'd7, 5'd31, 5'd2, 5'd16, 5'd5, 5'd12};
    bias_choice = '{85, 15, 50};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty deque at the reset capacity, then a capacity of three.
    send_op(deq_pkg::OP_QUERY, 32'h0);
    send_op(deq_pkg::OP_POP_FRONT, 32'h0);
    send_op(deq_pkg::OP_POP_REAR, 32'h0);
    send_op(3'd5, 32'h1234_5678);
    send_op(3'd7, 32'hFFFF_FFFF);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
    send_op(deq_pkg::OP_PUSH_REAR, 32'h7FFF_FFFF);
    wait_replies_done();
    write_capacity(5'd3);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    send_op(deq_pkg::OP_PUSH_REAR, 32'h0000_0000);
    send_op(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_A5A5);
    send_op(3'd6, 32'h0);
    send_op(deq_pkg::OP_POP_REAR, 32'h0);
    send_op(deq_pkg::OP_POP_FRONT, 32'h0);
    send_op(deq_pkg::OP_POP_FRONT, 32'h0);
    send_op(deq_pkg::OP_POP_REAR, 32'h0);
    send_op(deq_pkg::OP_POP_FRONT, 32'h0);

    for (int b = 0; b < BATCHES; b++) begin
      wait_replies_done();
      sender_idle_pct   = (b < 3) ? 29 : (b < 6) ? 87 : 0;
      receiver_idle_pct = (b < 3) ? 87 : (b < 6) ? 29 : 0;
      write_capacity(capacities[b]);
      for (int n = 0; n < BATCH_OPS; n++) begin
        if (n % 32 == 0) insert_bias = bias_choice[$urandom_range(0, 2)];
        if (b == 4 && n == BATCH_OPS / 2) wait_replies_done();
        send_op(pick_op(), pick_key());
      end
    end

    req_if.valid <= 1'b0;
    for (int i = 0; i < 20000 && shadow.pending() != 0; i++) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    shadow.close_out();
    if (shadow.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
